>>> rtl/assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/aft_pkg.sv
package aft_pkg;

  localparam int unsigned MaxEntries = 16;

  localparam logic [2:0]  ClearedStateRst = 3'd1;
  localparam logic [15:0] CountMax        = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_RAISE  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_LOOKUP = 2'd3
  } aft_cmd_e;

  typedef struct packed {
    aft_cmd_e    command;
    logic [15:0] fault_code;
    logic [2:0]  severity;
    logic [2:0]  fault_state;
    logic [7:0]  source_id;
    logic [31:0] measured_bits;
    logic [31:0] limit_bits;
    logic [31:0] now_ms;
    logic [3:0]  entry_index;
  } aft_in_t;

  typedef struct packed {
    logic        event_valid;
    logic        found;
    logic [15:0] out_code;
    logic [2:0]  out_severity;
    logic [2:0]  out_state;
    logic [7:0]  out_source;
    logic [31:0] out_measured;
    logic [31:0] out_limit;
    logic [31:0] out_timestamp;
    logic [15:0] out_occurrences;
    logic [4:0]  active_count;
  } aft_out_t;

  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  severity;
    logic [2:0]  state;
    logic [7:0]  source;
    logic [31:0] measured;
    logic [31:0] limit;
    logic [31:0] time_ms;
    logic [15:0] count;
  } aft_rec_t;

  typedef struct packed {
    logic match_en;
    logic update;
    logic append;
    logic shift;
  } aft_cell_ctrl_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
    sat_inc = (cnt == CountMax) ? cnt : cnt + 16'd1;
  endfunction

endpackage

>>> rtl/aft_cell.sv
module aft_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned POS_W    = 4
) (
  input  logic                    clk_i,
  input  aft_pkg::aft_cell_ctrl_t ctrl_i,
  input  aft_pkg::aft_in_t        req_i,
  input  logic [CNT_W-1:0]        occ_i,
  input  logic [POS_W-1:0]        pos_i,
  input  aft_pkg::aft_rec_t       next_i,
  output aft_pkg::aft_rec_t       rec_o,
  output logic                    sel_o
);

  aft_pkg::aft_rec_t rec_q;
  logic              sel_q;
  logic              sel_d;
  logic              occupied;

  assign occupied = CNT_W'(CELL_IDX) < occ_i;

  always_comb begin
    if (req_i.command == aft_pkg::CMD_READ) begin
      sel_d = occupied && (32'(req_i.entry_index) == CELL_IDX);
    end else begin
      sel_d = occupied && (req_i.fault_code != 16'd0) && (req_i.fault_code == rec_q.code);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.match_en) begin
      sel_q <= sel_d;
    end
    if (ctrl_i.update && sel_q) begin
      rec_q.severity <= req_i.severity;
      rec_q.state    <= req_i.fault_state;
      rec_q.source   <= req_i.source_id;
      rec_q.measured <= req_i.measured_bits;
      rec_q.limit    <= req_i.limit_bits;
      rec_q.count    <= aft_pkg::sat_inc(rec_q.count);
    end else if (ctrl_i.append && (CNT_W'(CELL_IDX) == occ_i)) begin
      rec_q.code     <= req_i.fault_code;
      rec_q.severity <= req_i.severity;
      rec_q.state    <= req_i.fault_state;
      rec_q.source   <= req_i.source_id;
      rec_q.measured <= req_i.measured_bits;
      rec_q.limit    <= req_i.limit_bits;
      rec_q.time_ms  <= req_i.now_ms;
      rec_q.count    <= 16'd1;
    end else if (ctrl_i.shift && (POS_W'(CELL_IDX) >= pos_i)) begin
      rec_q <= next_i;
    end
  end

  assign rec_o = rec_q;
  assign sel_o = sel_q;

endmodule

>>> rtl/active_fault_table.sv
// Channel   Direction  Payload             Handshake
// in        input      aft_pkg::aft_in_t   in_valid_i / in_stall_o
// out       output     aft_pkg::aft_out_t  out_valid_o / out_stall_i
// cfg       input      cleared state (3b)  cfg_we_i, no wait
//
// Each transaction passes through ST_MATCH, in which every cell of the
// record chain compares its code or position, then ST_COMMIT, in which the selected
// record is read out and the chain is updated (clear shifts the cells above).
// Reset empties the table at once; record contents stay undefined.
// A stalled output holds the commit cycle until the result register is free.
module active_fault_table #(
  parameter int unsigned MAX_ENTRIES = aft_pkg::MaxEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  aft_pkg::aft_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aft_pkg::aft_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PosW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMMIT
  } state_e;

  state_e                  state_q, state_d;
  aft_pkg::aft_in_t        req_q;
  logic [CntW-1:0]         occ_q, occ_d;
  logic [2:0]              clr_state_q;
  logic                    out_valid_q;
  aft_pkg::aft_out_t       out_q, out_d;

  aft_pkg::aft_rec_t       rec [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  sel;
  aft_pkg::aft_rec_t       rec_sel;
  logic [PosW-1:0]         pos;
  logic                    hit;
  logic                    out_free;
  logic                    commit;
  logic                    accept;
  aft_pkg::aft_cell_ctrl_t ctrl;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    aft_cell #(
      .CELL_IDX (i),
      .CNT_W    (CntW),
      .POS_W    (PosW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .req_i  (req_q),
      .occ_i  (occ_q),
      .pos_i  (pos),
      .next_i (rec[(i + 1 < MAX_ENTRIES) ? i + 1 : i]),
      .rec_o  (rec[i]),
      .sel_o  (sel[i])
    );
  end

  always_comb begin
    rec_sel = '0;
    pos     = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (sel[i]) begin
        rec_sel = rec_sel | rec[i];
        pos     = pos | PosW'(i);
      end
    end
  end

  assign hit      = |sel;
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == ST_COMMIT) && out_free;
  assign accept   = in_valid_i && !in_stall_o;

  assign in_stall_o = !((state_q == ST_IDLE) || commit);

  always_comb begin
    ctrl.match_en = state_q == ST_MATCH;
    ctrl.update   = commit && (req_q.command == aft_pkg::CMD_RAISE) && hit;
    ctrl.append   = commit && (req_q.command == aft_pkg::CMD_RAISE) && !hit
                    && (req_q.fault_code != 16'd0) && (occ_q < CntW'(MAX_ENTRIES));
    ctrl.shift    = commit && (req_q.command == aft_pkg::CMD_CLEAR) && hit;
  end

  always_comb begin
    if (ctrl.append) begin
      occ_d = occ_q + CntW'(1);
    end else if (ctrl.shift) begin
      occ_d = occ_q - CntW'(1);
    end else begin
      occ_d = occ_q;
    end
  end

  always_comb begin
    out_d = '0;
    case (req_q.command)
      aft_pkg::CMD_RAISE: begin
        if (hit) begin
          out_d.event_valid     = 1'b1;
          out_d.found           = 1'b1;
          out_d.out_code        = rec_sel.code;
          out_d.out_severity    = req_q.severity;
          out_d.out_state       = req_q.fault_state;
          out_d.out_source      = req_q.source_id;
          out_d.out_measured    = req_q.measured_bits;
          out_d.out_limit       = req_q.limit_bits;
          out_d.out_timestamp   = rec_sel.time_ms;
          out_d.out_occurrences = aft_pkg::sat_inc(rec_sel.count);
        end else if (ctrl.append) begin
          out_d.event_valid     = 1'b1;
          out_d.out_code        = req_q.fault_code;
          out_d.out_severity    = req_q.severity;
          out_d.out_state       = req_q.fault_state;
          out_d.out_source      = req_q.source_id;
          out_d.out_measured    = req_q.measured_bits;
          out_d.out_limit       = req_q.limit_bits;
          out_d.out_timestamp   = req_q.now_ms;
          out_d.out_occurrences = 16'd1;
        end
      end
      aft_pkg::CMD_CLEAR: begin
        if (hit) begin
          out_d.event_valid     = 1'b1;
          out_d.found           = 1'b1;
          out_d.out_code        = rec_sel.code;
          out_d.out_severity    = rec_sel.severity;
          out_d.out_state       = clr_state_q;
          out_d.out_source      = rec_sel.source;
          out_d.out_measured    = rec_sel.measured;
          out_d.out_limit       = rec_sel.limit;
          out_d.out_occurrences = rec_sel.count;
        end
      end
      aft_pkg::CMD_READ, aft_pkg::CMD_LOOKUP: begin
        if (hit) begin
          out_d.event_valid     = 1'b1;
          out_d.found           = 1'b1;
          out_d.out_code        = rec_sel.code;
          out_d.out_severity    = rec_sel.severity;
          out_d.out_state       = rec_sel.state;
          out_d.out_source      = rec_sel.source;
          out_d.out_measured    = rec_sel.measured;
          out_d.out_limit       = rec_sel.limit;
          out_d.out_timestamp   = rec_sel.time_ms;
          out_d.out_occurrences = rec_sel.count;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
    out_d.active_count = 5'(occ_d);
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_MATCH;
    end else if (state_q == ST_MATCH) begin
      state_d = ST_COMMIT;
    end else if (commit) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      clr_state_q <= aft_pkg::ClearedStateRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        clr_state_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  // codes in the table are unique, so at most one cell may be selected
  `ASSERT_STD(a_sel_onehot, (state_q == ST_COMMIT) |-> $onehot0(sel), "several cells selected")
  `ASSERT_STD(a_occ_range, occ_q <= CntW'(MAX_ENTRIES), "occupancy beyond table size")
  `ASSERT_STD(a_shift_nonempty, ctrl.shift |-> (occ_q != '0), "clear on an empty table")
  `ASSERT_STD(a_commit_out, commit |=> out_valid_q, "commit without result")
  `ASSERT_STD(a_accept_match, accept |=> (state_q == ST_MATCH), "accepted item not matched")

endmodule
